FILE: design/bsf_pkg.sv
package bsf_pkg;

  localparam int CFG_W = 16;
  localparam int POS_W = 32;
  localparam int IDX_W = 10;
  localparam int QUO_W = 19;
  localparam int DIV_STEPS = QUO_W;
  localparam int EXP_W = 31;
  localparam int TAB_N = 257;

  localparam int DEF_NUM_BOWS = 4;
  localparam int DEF_MASS_INDEX_BITS = 10;

  localparam logic [1:0] REG_GAIN = 2'd0;
  localparam logic [1:0] REG_SCALE = 2'd1;
  localparam logic [1:0] REG_CONTACT = 2'd2;

  localparam logic [CFG_W-1:0] GAIN_RESET = 16'd32768;
  localparam logic [CFG_W-1:0] SCALE_RESET = 16'd1311;
  localparam logic [CFG_W-1:0] CONTACT_RESET = 16'd11796;

  localparam logic [15:0] COEF_063 = 16'd41288;
  localparam logic [31:0] EXP_HALF = 32'd1770300985;
  localparam logic [31:0] EXP_STEP = 32'd947573834;

  typedef logic [EXP_W-1:0] exp_tab_t [0:TAB_N-1];

  // exp(0.5 - t) in Q30 at steps of t = 1/8
  function automatic exp_tab_t exp_tab_gen();
    exp_tab_t t;
    logic [63:0] a;
    t[0] = EXP_HALF[EXP_W-1:0];
    for (int i = 0; i < TAB_N - 1; i++) begin
      a = 64'(t[i]) * 64'(EXP_STEP) + 64'h2000_0000;
      t[i+1] = a[EXP_W+29:30];
    end
    return t;
  endfunction

  localparam exp_tab_t EXP_TAB = exp_tab_gen();

  typedef struct packed {
    logic vel;
    logic div;
    logic sq;
    logic tab;
    logic intp;
    logic kmul;
    logic fmul;
    logic done;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } stat_t;

endpackage

FILE: design/bsf_ctrl.sv
module bsf_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  bsf_pkg::stat_t stat,
  output bsf_pkg::cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_VEL, S_DIV, S_SQ, S_TAB, S_INTP, S_KMUL, S_FMUL, S_DONE
  } state_t;

  state_t state;
  logic [4:0] cnt;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd = '0;
    cmd.vel  = (state == S_VEL);
    cmd.div  = (state == S_DIV);
    cmd.sq   = (state == S_SQ);
    cmd.tab  = (state == S_TAB);
    cmd.intp = (state == S_INTP);
    cmd.kmul = (state == S_KMUL);
    cmd.fmul = (state == S_FMUL);
    cmd.done = (state == S_DONE) && stat.out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt <= '0;
    end else begin
      case (state)
        S_IDLE: if (in_valid) state <= S_VEL;
        S_VEL: begin
          cnt <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          cnt <= cnt + 5'd1;
          if (cnt == 5'(bsf_pkg::DIV_STEPS - 1)) state <= S_SQ;
        end
        S_SQ:   state <= S_TAB;
        S_TAB:  state <= S_INTP;
        S_INTP: state <= S_KMUL;
        S_KMUL: state <= S_FMUL;
        S_FMUL: state <= S_DONE;
        S_DONE: if (stat.out_free) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: design/bsf_dp.sv
module bsf_dp #(
  parameter int NUM_BOWS = bsf_pkg::DEF_NUM_BOWS,
  parameter int MASS_INDEX_BITS = bsf_pkg::DEF_MASS_INDEX_BITS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [15:0]          cfg_data,
  input  logic                 accept,
  input  logic                 func,
  input  logic [1:0]           bow,
  input  logic signed [31:0]   bow_position,
  input  logic                 active,
  input  logic [9:0]           string_start,
  input  logic [9:0]           string_end,
  input  logic signed [31:0]   mass_pos,
  input  logic signed [31:0]   mass_prev_pos,
  input  bsf_pkg::cmd_t        cmd,
  output bsf_pkg::stat_t       stat,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [9:0]           contact_index,
  output logic signed [31:0]   friction_force,
  output logic                 applied,
  output logic signed [31:0]   accumulated_force
);

  localparam int BW = (NUM_BOWS > 1) ? $clog2(NUM_BOWS) : 1;
  localparam logic [9:0] IDX_MASK = 10'((33'd1 << MASS_INDEX_BITS) - 33'd1);

  logic [15:0] gain, scale, contact;

  logic signed [31:0] bow_now [NUM_BOWS];
  logic signed [31:0] bow_before [NUM_BOWS];
  logic signed [31:0] bow_sum [NUM_BOWS];

  // captured item
  logic        c_func, c_act, c_ok;
  logic [BW-1:0] c_bi;
  logic signed [31:0] c_pos, c_mp, c_mpp, c_bn, c_bb;
  logic [9:0]  c_start, c_end;
  logic [15:0] c_s;
  logic [31:0] zg;

  logic [33:0] mag;
  logic        neg, ovf, ez;
  logic [9:0]  idx;
  logic [16:0] rem;
  logic [18:0] dsh;
  logic [18:0] quo;
  logic [7:0]  tk;
  logic [12:0] tfr;
  logic [30:0] g0;
  logic [43:0] dprod;
  logic [30:0] e;
  logic [24:0] kf;
  logic [34:0] fm;

  logic          ok_in;
  logic [BW-1:0] bi_in;
  assign ok_in = 32'(bow) < NUM_BOWS;
  assign bi_in = BW'(bow);

  // velocity and index
  logic signed [33:0] vel_c;
  logic signed [10:0] span;
  logic [9:0]  aspan, off;
  logic [25:0] offp;
  always_comb begin
    vel_c = (34'(c_mp) - 34'(c_mpp)) - (34'(c_bn) - 34'(c_bb));
    span = $signed({1'b0, c_end}) - $signed({1'b0, c_start});
    aspan = span[10] ? 10'(-span) : span[9:0];
    offp = 26'(aspan) * 26'(contact);
    off = offp[25:16];
  end

  logic [16:0] trial;
  assign trial = {rem[15:0], dsh[18]};

  logic [37:0] sqr;
  assign sqr = 38'(quo) * 38'(quo);

  logic [62:0] kp;
  assign kp = 63'(zg) * 63'(e);
  logic [58:0] fp;
  assign fp = 59'(mag) * 59'(kf);

  // saturation
  logic signed [35:0] fs;
  logic signed [31:0] force_sat;
  logic signed [32:0] sum_w;
  logic signed [31:0] sum_sat;
  always_comb begin
    fs = neg ? -$signed({1'b0, fm}) : $signed({1'b0, fm});
    if (fs > 36'sd2147483647) force_sat = 32'sh7fffffff;
    else if (fs < -36'sd2147483648) force_sat = 32'sh80000000;
    else force_sat = fs[31:0];
    sum_w = 33'(bow_sum[c_bi]) + 33'(force_sat);
    if (sum_w > 33'sd2147483647) sum_sat = 32'sh7fffffff;
    else if (sum_w < -33'sd2147483648) sum_sat = 32'sh80000000;
    else sum_sat = sum_w[31:0];
  end

  assign stat.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain <= bsf_pkg::GAIN_RESET;
      scale <= bsf_pkg::SCALE_RESET;
      contact <= bsf_pkg::CONTACT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        bsf_pkg::REG_GAIN:    gain <= cfg_data;
        bsf_pkg::REG_SCALE:   scale <= cfg_data;
        bsf_pkg::REG_CONTACT: contact <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      for (int i = 0; i < NUM_BOWS; i++) begin
        bow_now[i] <= '0;
        bow_before[i] <= '0;
        bow_sum[i] <= '0;
      end
    end else begin
      if (cmd.done) begin
        out_valid <= 1'b1;
        contact_index <= (c_ok && c_func) ? idx : '0;
        friction_force <= (c_ok && c_func && c_act) ? force_sat : '0;
        applied <= c_ok && c_func && c_act;
        if (!(c_ok && c_func)) accumulated_force <= '0;
        else if (c_act) accumulated_force <= sum_sat;
        else accumulated_force <= bow_sum[c_bi];
        if (c_ok) begin
          if (!c_func) begin
            bow_before[c_bi] <= bow_now[c_bi];
            bow_now[c_bi] <= c_pos;
            bow_sum[c_bi] <= '0;
          end else if (c_act) begin
            bow_sum[c_bi] <= sum_sat;
          end
        end
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      c_func <= func;
      c_act <= active;
      c_ok <= ok_in;
      c_bi <= bi_in;
      c_pos <= bow_position;
      c_mp <= mass_pos;
      c_mpp <= mass_prev_pos;
      c_start <= string_start;
      c_end <= string_end;
      c_bn <= ok_in ? bow_now[bi_in] : '0;
      c_bb <= ok_in ? bow_before[bi_in] : '0;
      c_s <= (scale == 16'd0) ? 16'd1 : scale;
      zg <= 32'(gain) * 32'(bsf_pkg::COEF_063);
    end
    if (cmd.vel) begin
      neg <= vel_c[33];
      mag <= vel_c[33] ? 34'(-vel_c) : 34'(vel_c);
      idx <= (span[10] ? (c_start - off) : (c_start + off)) & IDX_MASK;
      // quotient of (mag << 8) / s must fit in QUO_W bits
      ovf <= (vel_c[33] ? 34'(-vel_c) : 34'(vel_c)) >= {7'd0, c_s, 11'd0};
      rem <= 17'(vel_c[33] ? 34'(-vel_c) >> 11 : 34'(vel_c) >> 11);
      dsh <= {(vel_c[33] ? 11'(-vel_c) : vel_c[10:0]), 8'd0};
      quo <= '0;
    end
    if (cmd.div) begin
      if (trial >= {1'b0, c_s}) begin
        rem <= trial - {1'b0, c_s};
        quo <= {quo[17:0], 1'b1};
      end else begin
        rem <= trial;
        quo <= {quo[17:0], 1'b0};
      end
      dsh <= {dsh[17:0], 1'b0};
    end
    if (cmd.sq) begin
      ez <= ovf || (sqr[37:35] != 3'd0);
      tk <= sqr[34:27];
      tfr <= sqr[26:14];
    end
    if (cmd.tab) begin
      g0 <= bsf_pkg::EXP_TAB[9'(tk)];
      dprod <= 44'(bsf_pkg::EXP_TAB[9'(tk)] - bsf_pkg::EXP_TAB[9'(tk) + 9'd1]) * 44'(tfr);
    end
    if (cmd.intp) e <= ez ? '0 : g0 - dprod[43:13];
    if (cmd.kmul) kf <= kp[62:38];
    if (cmd.fmul) fm <= fp[58:24];
  end

endmodule

FILE: design/bowed_string_friction.sv
// Bowed-string friction for up to NUM_BOWS bows. A load beat (func 0)
// shifts in a new bow position and clears that bow's accumulated force; a
// friction beat (func 1) returns the contact mass index and, for an active
// bow, f = 0.63*Z*v*exp(0.5 - 4*(v/scale)^2) in signed Q8.24, saturated,
// and adds it to the bow's accumulated force. After acceptance the velocity
// is formed, then the velocity/scale quotient comes from a restoring divider,
// one bit per cycle, followed by square, table lookup, interpolation and two
// multiply stages. The last step waits while the output register still
// holds an unaccepted result. A new item is accepted once the controller is
// idle; a finished result may wait in the output register meanwhile.
// Configuration writes take effect at once and belong between items.
module bowed_string_friction #(
  parameter int NUM_BOWS = bsf_pkg::DEF_NUM_BOWS,
  parameter int MASS_INDEX_BITS = bsf_pkg::DEF_MASS_INDEX_BITS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                func,
  input  logic [1:0]          bow,
  input  logic signed [31:0]  bow_position,
  input  logic                active,
  input  logic [9:0]          string_start,
  input  logic [9:0]          string_end,
  input  logic signed [31:0]  mass_pos,
  input  logic signed [31:0]  mass_prev_pos,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [9:0]          contact_index,
  output logic signed [31:0]  friction_force,
  output logic                applied,
  output logic signed [31:0]  accumulated_force
);

  bsf_pkg::cmd_t  cmd;
  bsf_pkg::stat_t stat;

  bsf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  bsf_dp #(
    .NUM_BOWS        (NUM_BOWS),
    .MASS_INDEX_BITS (MASS_INDEX_BITS)
  ) u_dp (
    .clk               (clk),
    .rst               (rst),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .accept            (in_valid && in_ready),
    .func              (func),
    .bow               (bow),
    .bow_position      (bow_position),
    .active            (active),
    .string_start      (string_start),
    .string_end        (string_end),
    .mass_pos          (mass_pos),
    .mass_prev_pos     (mass_prev_pos),
    .cmd               (cmd),
    .stat              (stat),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .contact_index     (contact_index),
    .friction_force    (friction_force),
    .applied           (applied),
    .accumulated_force (accumulated_force)
  );

endmodule

FILE: test/bowed_string_friction_tb.sv
`timescale 1ns / 1ps

module bowed_string_friction_tb;

  localparam int N_BOWS = bsf_pkg::DEF_NUM_BOWS;

  typedef struct packed {
    logic [9:0]  contact_index;
    logic [31:0] friction_force;
    logic        applied;
    logic [31:0] accumulated_force;
  } friction_res_t;

  typedef struct {
    logic        func;
    logic [1:0]  bow;
    logic [31:0] bow_position;
    logic        active;
    logic [9:0]  string_start;
    logic [9:0]  string_end;
    logic [31:0] mass_pos;
    logic [31:0] mass_prev_pos;
  } bow_beat_t;

  class friction_scoreboard;
    logic [30:0] exp_lut [0:256];
    longint pos_now [N_BOWS];
    longint pos_old [N_BOWS];
    longint force_sum [N_BOWS];
    logic [15:0] gain, scale, contact;
    friction_res_t pending[$];
    int mismatches;

    function new();
      logic [63:0] a;
      exp_lut[0] = 31'd1770300985;
      for (int i = 0; i < 256; i++) begin
        a = 64'(exp_lut[i]) * 64'd947573834 + 64'h2000_0000;
        exp_lut[i+1] = a[60:30];
      end
      for (int i = 0; i < N_BOWS; i++) begin
        pos_now[i] = 0;
        pos_old[i] = 0;
        force_sum[i] = 0;
      end
      gain = 16'd32768;
      scale = 16'd1311;
      contact = 16'd11796;
      mismatches = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [15:0] val);
      case (idx)
        bsf_pkg::REG_GAIN: gain = val;
        bsf_pkg::REG_SCALE: scale = val;
        bsf_pkg::REG_CONTACT: contact = val;
        default: ;
      endcase
    endfunction

    function longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function longint exp_factor(longint mag);
      longint unsigned s, u, t, k, fr, hi, lo;
      s = (scale == 0) ? 1 : scale;
      u = (mag << 8) / s;
      if (u >= (1 << 19)) return 0;
      t = (u * u) >> 14;
      if (t >= (32 << 16)) return 0;
      k = t >> 13;
      fr = t & 8191;
      hi = exp_lut[k];
      lo = exp_lut[k+1];
      return hi - (((hi - lo) * fr) >> 13);
    endfunction

    function void note_beat(bow_beat_t b);
      friction_res_t r;
      longint span, off, idx, vel, mag, f;
      longint unsigned e, kf, prod;
      logic [127:0] wide;
      r = '{default: '0};
      if (b.bow < N_BOWS) begin
        if (!b.func) begin
          pos_old[b.bow] = pos_now[b.bow];
          pos_now[b.bow] = longint'(signed'(b.bow_position));
          force_sum[b.bow] = 0;
        end else begin
          span = longint'(b.string_end) - longint'(b.string_start);
          if (span >= 0) off = (span * contact) >>> 16;
          else off = -(((-span) * contact) >>> 16);
          idx = b.string_start + off;
          r.contact_index = idx[9:0];
          if (b.active) begin
            vel = (longint'(signed'(b.mass_pos)) - longint'(signed'(b.mass_prev_pos)))
                  - (pos_now[b.bow] - pos_old[b.bow]);
            mag = vel < 0 ? -vel : vel;
            e = exp_factor(mag);
            wide = 128'(gain) * 128'd41288 * 128'(e);
            kf = 64'(wide >> 38);
            wide = 128'(mag) * 128'(kf);
            prod = 64'(wide >> 24);
            f = clamp32(vel < 0 ? -longint'(prod) : longint'(prod));
            force_sum[b.bow] = clamp32(force_sum[b.bow] + f);
            r.friction_force = f[31:0];
            r.applied = 1'b1;
          end
          r.accumulated_force = force_sum[b.bow][31:0];
        end
      end
      pending.push_back(r);
    endfunction

    function bit check_result(friction_res_t got);
      friction_res_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat idx=%0d f=%0d",
                                       got.contact_index, got.friction_force);
        return 0;
      end
      want = pending.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp idx=%0d f=%h ap=%0b acc=%h, got idx=%0d f=%h ap=%0b acc=%h",
                   want.contact_index, want.friction_force, want.applied,
                   want.accumulated_force, got.contact_index, got.friction_force,
                   got.applied, got.accumulated_force);
        return 0;
      end
      return 1;
    endfunction
  endclass

  logic clk, rst;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [15:0] cfg_data;
  logic in_valid, in_ready, out_valid, out_ready;
  logic func, active, applied;
  logic [1:0] bow;
  logic signed [31:0] bow_position, mass_pos, mass_prev_pos;
  logic [9:0] string_start, string_end, contact_index;
  logic signed [31:0] friction_force, accumulated_force;

  friction_scoreboard sb;
  bit in_idle_en, out_idle_en;
  bit done_sending;

  bowed_string_friction dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .func(func), .bow(bow), .bow_position(bow_position), .active(active),
    .string_start(string_start), .string_end(string_end),
    .mass_pos(mass_pos), .mass_prev_pos(mass_prev_pos),
    .out_valid(out_valid), .out_ready(out_ready),
    .contact_index(contact_index), .friction_force(friction_force),
    .applied(applied), .accumulated_force(accumulated_force)
  );

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("bowed_string_friction_tb NOT OK");
    $finish;
  end

  // starts on the falling edge after the previous beat; valid stays high
  // into the next beat unless an idle burst comes first
  task automatic send_beat(bow_beat_t b);
    int gap;
    @(negedge clk);
    if (in_idle_en && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 19);
      repeat (gap) @(negedge clk);
    end
    func <= b.func;
    bow <= b.bow;
    bow_position <= b.bow_position;
    active <= b.active;
    string_start <= b.string_start;
    string_end <= b.string_end;
    mass_pos <= b.mass_pos;
    mass_prev_pos <= b.mass_prev_pos;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    sb.note_beat(b);
  endtask

  task automatic write_cfg(logic [1:0] idx, logic [15:0] val);
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.write_reg(idx, val);
  endtask

  function automatic logic [31:0] pick_pos();
    case ($urandom_range(0, 5))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return $urandom;
      default: return 32'($signed($urandom_range(0, 16'hffff)) - 32768);
    endcase
  endfunction

  function automatic bow_beat_t rand_beat();
    bow_beat_t b;
    logic [31:0] base;
    b.func = ($urandom_range(0, 3) != 0);
    b.bow = 2'($urandom_range(0, 3));
    b.bow_position = pick_pos();
    b.active = ($urandom_range(0, 5) != 0);
    b.string_start = 10'($urandom_range(0, 1023));
    b.string_end = 10'($urandom_range(0, 1023));
    base = $urandom;
    if ($urandom_range(0, 3) == 0) begin
      b.mass_pos = pick_pos();
      b.mass_prev_pos = pick_pos();
    end else begin
      // small velocities land on the interesting part of the curve
      b.mass_pos = base;
      b.mass_prev_pos = base - 32'($signed($urandom_range(0, 16'hffff)) - 32768);
    end
    return b;
  endfunction

  // result side: random stall bursts
  initial begin
    friction_res_t got;
    int gap;
    out_ready = 1'b0;
    @(negedge clk);
    forever begin
      if (out_idle_en && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        gap = $urandom_range(1, 19);
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      if (out_valid && out_ready) begin
        got.contact_index = contact_index;
        got.friction_force = friction_force;
        got.applied = applied;
        got.accumulated_force = accumulated_force;
        void'(sb.check_result(got));
      end
      @(negedge clk);
    end
  end

  initial begin
    bow_beat_t b;
    int waited;
    sb = new();
    rst = 1'b1;
    cfg_we = 1'b0; cfg_index = bsf_pkg::REG_GAIN; cfg_data = '0;
    in_valid = 1'b0; func = 0; bow = 0; bow_position = 0; active = 0;
    string_start = 0; string_end = 0; mass_pos = 0; mass_prev_pos = 0;
    in_idle_en = 1; out_idle_en = 1;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: loads, extremes, reversed string, inactive, bow overflow risk
    b = '{1'b0, 2'd0, 32'h0100_0000, 1'b0, 10'd0, 10'd0, 32'd0, 32'd0};
    send_beat(b);
    b = '{1'b0, 2'd0, 32'h0000_0000, 1'b0, 10'd0, 10'd0, 32'd0, 32'd0};
    send_beat(b);
    b = '{1'b1, 2'd0, 32'd0, 1'b1, 10'd0, 10'd1023, 32'd0, 32'd0};
    send_beat(b);
    b = '{1'b1, 2'd0, 32'd0, 1'b1, 10'd1023, 10'd0, 32'd100, 32'd0};
    send_beat(b);
    b = '{1'b1, 2'd1, 32'd0, 1'b0, 10'd100, 10'd200, 32'd5000, 32'd0};
    send_beat(b);
    b = '{1'b1, 2'd2, 32'd0, 1'b1, 10'd5, 10'd5, 32'h7fff_ffff, 32'h8000_0000};
    send_beat(b);
    b = '{1'b1, 2'd3, 32'd0, 1'b1, 10'd10, 10'd3, 32'h8000_0000, 32'h7fff_ffff};
    send_beat(b);
    b = '{1'b1, 2'd1, 32'd0, 1'b1, 10'd0, 10'd500, 32'd8000, 32'd0};
    send_beat(b);
    b = '{1'b1, 2'd1, 32'd0, 1'b1, 10'd0, 10'd500, -32'sd8000, 32'd0};
    send_beat(b);
    b = '{1'b0, 2'd3, 32'hffff_ffff, 1'b1, 10'd1023, 10'd1023, 32'hffff_ffff, 32'hffff_ffff};
    send_beat(b);

    // gain max, tiny scale: large forces, saturating accumulator
    write_cfg(bsf_pkg::REG_GAIN, 16'hffff);
    write_cfg(bsf_pkg::REG_SCALE, 16'd0);
    write_cfg(bsf_pkg::REG_CONTACT, 16'hffff);
    for (int i = 0; i < 12; i++) begin
      b = '{1'b1, 2'd2, 32'd0, 1'b1, 10'd0, 10'd1023, 32'd1 << (i % 10), 32'd0};
      send_beat(b);
    end
    for (int i = 0; i < 200; i++) send_beat(rand_beat());

    write_cfg(bsf_pkg::REG_SCALE, 16'hffff);
    write_cfg(bsf_pkg::REG_CONTACT, 16'd0);
    write_cfg(bsf_pkg::REG_GAIN, 16'd0);
    for (int i = 0; i < 100; i++) send_beat(rand_beat());

    write_cfg(bsf_pkg::REG_GAIN, 16'd40000);
    write_cfg(bsf_pkg::REG_SCALE, 16'd1311);
    write_cfg(bsf_pkg::REG_CONTACT, 16'd11796);
    for (int i = 0; i < 250; i++) send_beat(rand_beat());

    write_cfg(bsf_pkg::REG_GAIN, 16'($urandom));
    write_cfg(bsf_pkg::REG_SCALE, 16'($urandom_range(1, 5000)));
    write_cfg(bsf_pkg::REG_CONTACT, 16'($urandom));
    for (int i = 0; i < 150; i++) send_beat(rand_beat());

    in_idle_en = 0;
    out_idle_en = 0;
    for (int i = 0; i < 150; i++) send_beat(rand_beat());

    @(negedge clk);
    in_valid <= 1'b0;
    waited = 0;
    while (sb.pending.size() != 0 && waited < 100000) begin
      @(negedge clk);
      waited++;
    end
    repeat (60) @(negedge clk);
    if (sb.mismatches == 0 && sb.pending.size() == 0)
      $display("bowed_string_friction_tb OK");
    else
      $display("bowed_string_friction_tb NOT OK");
    $finish;
  end

endmodule
